### sv/pwg_pkg.sv
// ============================================================================
// pwg_pkg
// Shared types, constants and the quarter-wave sine table of the
// periodic waveform generator.
// ============================================================================
`default_nettype none

package pwg_pkg;

    // ------------------------------------------------------------------------
    // Field widths
    // ------------------------------------------------------------------------
    localparam int TIME_W      = 48;
    localparam int TIME_HALF_W = TIME_W / 2;
    localparam int FREQ_W      = 24;
    localparam int PHASE_W     = 32;
    localparam int AMP_W       = 16;
    localparam int SAMPLE_W    = 16;
    localparam int KIND_W      = 3;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    // Partial products of time * frequency
    localparam int PART_W = TIME_HALF_W + FREQ_W;
    localparam int PROD_W = TIME_W + FREQ_W;

    // ------------------------------------------------------------------------
    // Phase reduction: u = floor(time * freq * 1024 / 15625) mod 2^32,
    // done as a long division by 15625 with 16-bit quotient digits.
    // ------------------------------------------------------------------------
    localparam int DIGIT_W      = 16;
    localparam int REM_W        = 14;
    localparam int PHASE_PAD_W  = 10;
    localparam int DIGIT_COUNT  = 5;
    localparam int STREAM_W     = DIGIT_W * DIGIT_COUNT;
    localparam int DIV_TOP_W    = PROD_W + PHASE_PAD_W - STREAM_W;
    localparam int DIV_VALUE_W  = REM_W + DIGIT_W;
    localparam int DIV_M_W      = 31;
    localparam int DIV_PROD_W   = DIV_VALUE_W + DIV_M_W;
    localparam int DIV_SHIFT    = 44;
    localparam logic [REM_W-1:0]   DIV_D = 14'd15625;
    // floor(2^44 / 15625): estimate is exact or one low
    localparam logic [DIV_M_W-1:0] DIV_M = 31'd1125899906;

    // ------------------------------------------------------------------------
    // Shapes, Q1.14
    // ------------------------------------------------------------------------
    localparam int SHAPE_W = 16;
    localparam logic [SHAPE_W-1:0] SHAPE_ONE       = 16'h4000;
    localparam logic [SHAPE_W-1:0] SHAPE_MINUS_ONE = 16'hC000;
    localparam logic [SHAPE_W-1:0] TRI_PEAK        = 16'hC000;
    localparam logic [PHASE_W-1:0] QUARTER_TURN    = 32'h4000_0000;

    // Register to output, in clock cycles
    localparam int PIPE_LATENCY = 19;

    // ------------------------------------------------------------------------
    // Codes
    // ------------------------------------------------------------------------
    typedef enum logic [KIND_W-1:0] {
        WAVE_SINE     = 3'd0,
        WAVE_COSINE   = 3'd1,
        WAVE_SQUARE   = 3'd2,
        WAVE_TRIANGLE = 3'd3,
        WAVE_SAWTOOTH = 3'd4,
        WAVE_OFFSET   = 3'd5
    } wave_kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WAVE_KIND    = 3'd0,
        REG_FREQUENCY_HZ = 3'd1,
        REG_PHASE_OFFSET = 3'd2,
        REG_AMPLITUDE    = 3'd3,
        REG_OFFSET       = 3'd4
    } cfg_reg_t;

    // Register reset values
    localparam logic [KIND_W-1:0]  WAVE_KIND_RESET    = WAVE_SINE;
    localparam logic [FREQ_W-1:0]  FREQUENCY_RESET    = 24'd32768;
    localparam logic [PHASE_W-1:0] PHASE_OFFSET_RESET = 32'd0;
    localparam logic [AMP_W-1:0]   AMPLITUDE_RESET    = 16'd256;
    localparam logic [AMP_W-1:0]   OFFSET_RESET       = 16'd0;

    // ------------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [KIND_W-1:0]       wave_kind;
        logic [FREQ_W-1:0]       frequency_hz;
        logic [PHASE_W-1:0]      phase_offset;
        logic signed [AMP_W-1:0] amplitude;
        logic signed [AMP_W-1:0] offset;
    } pwg_cfg_t;

    typedef struct packed {
        logic                valid;
        logic [REM_W-1:0]    rem;
        logic [STREAM_W-1:0] stream;
    } digit_bus_t;

    // ------------------------------------------------------------------------
    // Quarter-wave sine table, Q1.14, built at elaboration from a
    // fixed-point Taylor series in Q30.
    // ------------------------------------------------------------------------
    localparam int SINE_TABLE_LOG2 = 10;
    localparam int SINE_TBL_N      = 1 << SINE_TABLE_LOG2;
    localparam int SINE_ADDR_W     = SINE_TABLE_LOG2 + 1;
    localparam int SINE_W          = 15;
    localparam int SERIES_TERMS    = 10;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // ceil(2^41 / ((2n)(2n+1))) per series term; multiply and shift by 41
    // is an exact floor division for dividends below 2^32
    localparam int RECIP_SHIFT = 41;
    typedef logic [63:0] series_recip_t [1:SERIES_TERMS];
    localparam series_recip_t SERIES_RECIP = '{
        ((64'd1 << RECIP_SHIFT) + 64'd5)   / 64'd6,
        ((64'd1 << RECIP_SHIFT) + 64'd19)  / 64'd20,
        ((64'd1 << RECIP_SHIFT) + 64'd41)  / 64'd42,
        ((64'd1 << RECIP_SHIFT) + 64'd71)  / 64'd72,
        ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110,
        ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156,
        ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210,
        ((64'd1 << RECIP_SHIFT) + 64'd271) / 64'd272,
        ((64'd1 << RECIP_SHIFT) + 64'd341) / 64'd342,
        ((64'd1 << RECIP_SHIFT) + 64'd419) / 64'd420
    };

    typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_TBL_N];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t    rom;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  pos;
        logic [63:0]  neg;
        logic [63:0]  s;
        logic [63:0]  e;
        logic [127:0] wide;
        for (int k = 0; k <= SINE_TBL_N; k++)
        begin
            x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_LOG2;
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = '0;
            for (int n = 1; n <= SERIES_TERMS; n++)
            begin
                wide = 128'((term * x2) >> 30) * 128'(SERIES_RECIP[n]);
                term = wide[RECIP_SHIFT +: 64];
                if ((n & 1) == 1)
                begin
                    neg = neg + term;
                end
                else
                begin
                    pos = pos + term;
                end
            end
            s = (pos > neg) ? pos - neg : 64'd0;
            e = (s + 64'd32768) >> 16;
            if (e > 64'd16384)
            begin
                e = 64'd16384;
            end
            rom[k] = e[SINE_W-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

### sv/periodic_waveform_generator.sv
// ============================================================================
// periodic_waveform_generator
// Samples a sine, cosine, square, triangle or sawtooth wave at a given time.
// ============================================================================
// Usage:
//   Input: drive time_usec with start high; the transfer happens at a
//   rising edge with start high and busy low. busy is high only in the
//   first cycle after reset, so one sample can enter every clock.
//   Output: each sample appears on sample for one cycle with done high;
//   order is preserved. Throughput is one sample per clock; the longest
//   part of the pipeline is the five two-stage division digits that
//   reduce time * frequency to a phase.
//   The receiver cannot stall: done is not held, so it must take every
//   sample in its cycle.
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr
//   (0 wave kind, 1 frequency, 2 phase offset, 3 amplitude, 4 offset);
//   other indexes are ignored. Write only while no sample is in flight.
//   Reset: asynchronous, active low; clears the pipeline and loads the
//   register defaults (sine, 0.5 Hz, no phase offset, gain 1.0, offset 0).
// ============================================================================
`default_nettype none

module periodic_waveform_generator
    import pwg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [TIME_W-1:0]        time_usec,
    output logic                          done,
    output logic signed [SAMPLE_W-1:0]    sample,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]    cfg_wdata
);

    logic                    busy_reg;
    logic [KIND_W-1:0]       wave_kind_reg;
    logic [FREQ_W-1:0]       frequency_reg;
    logic [PHASE_W-1:0]      phase_offset_reg;
    logic [AMP_W-1:0]        amplitude_reg;
    logic [AMP_W-1:0]        offset_reg;

    pwg_cfg_t                cfg;
    logic                    accept;
    logic                    phase_valid;
    logic [PHASE_W-1:0]      phase;
    logic                    shape_valid;
    logic signed [SHAPE_W-1:0] shape;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b1;
            wave_kind_reg    <= WAVE_KIND_RESET;
            frequency_reg    <= FREQUENCY_RESET;
            phase_offset_reg <= PHASE_OFFSET_RESET;
            amplitude_reg    <= AMPLITUDE_RESET;
            offset_reg       <= OFFSET_RESET;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_WAVE_KIND:    wave_kind_reg    <= cfg_wdata[KIND_W-1:0];
                    REG_FREQUENCY_HZ: frequency_reg    <= cfg_wdata[FREQ_W-1:0];
                    REG_PHASE_OFFSET: phase_offset_reg <= cfg_wdata[PHASE_W-1:0];
                    REG_AMPLITUDE:    amplitude_reg    <= cfg_wdata[AMP_W-1:0];
                    REG_OFFSET:       offset_reg       <= cfg_wdata[AMP_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.wave_kind    = wave_kind_reg;
        cfg.frequency_hz = frequency_reg;
        cfg.phase_offset = phase_offset_reg;
        cfg.amplitude    = $signed(amplitude_reg);
        cfg.offset       = $signed(offset_reg);
    end

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    pwg_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .time_usec (time_usec),
        .cfg       (cfg),
        .out_valid (phase_valid),
        .phase     (phase)
    );

    pwg_shape u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (phase_valid),
        .phase     (phase),
        .cfg       (cfg),
        .out_valid (shape_valid),
        .shape     (shape)
    );

    pwg_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (shape_valid),
        .shape     (shape),
        .cfg       (cfg),
        .out_valid (done),
        .sample    (sample)
    );

endmodule

`default_nettype wire

### sv/pwg_div_digit.sv
// ============================================================================
// pwg_div_digit
// One 16-bit quotient digit of the long division by 15625: reciprocal
// estimate, then remainder and a single correction step.
// ============================================================================
`default_nettype none

module pwg_div_digit
    import pwg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire digit_bus_t din,
    output digit_bus_t      dout
);

    logic [DIV_VALUE_W-1:0] value_next;
    logic [DIV_PROD_W-1:0]  est_prod;

    logic                         a_valid_reg;
    logic [DIV_VALUE_W-1:0]       value_reg;
    logic [DIGIT_W-1:0]           q_est_reg;
    logic [STREAM_W-DIGIT_W-1:0]  rest_reg;

    logic [DIV_VALUE_W-1:0] rem_wide;
    logic [REM_W:0]         rem_raw;
    logic                   fix;
    logic [DIGIT_W-1:0]     q_fix;
    logic [REM_W-1:0]       rem_fix;

    logic                b_valid_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [STREAM_W-1:0] stream_reg;

    // Partial dividend: remainder so far followed by the next digit
    assign value_next = {din.rem, din.stream[STREAM_W-1 -: DIGIT_W]};
    assign est_prod   = DIV_PROD_W'(value_next) * DIV_PROD_W'(DIV_M);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= din.valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        q_est_reg  <= est_prod[DIV_SHIFT +: DIGIT_W];
        rest_reg   <= din.stream[STREAM_W-DIGIT_W-1:0];
        rem_reg    <= rem_fix;
        stream_reg <= {rest_reg, q_fix};
    end

    // Estimate is never high, so the raw remainder lies below 2 * 15625
    assign rem_wide = value_reg - DIV_VALUE_W'(q_est_reg) * DIV_VALUE_W'(DIV_D);
    assign rem_raw  = rem_wide[REM_W:0];
    assign fix      = (rem_raw >= {1'b0, DIV_D});
    assign q_fix    = fix ? q_est_reg + DIGIT_W'(1) : q_est_reg;
    assign rem_fix  = fix ? REM_W'(rem_raw - {1'b0, DIV_D}) : rem_raw[REM_W-1:0];

    assign dout.valid  = b_valid_reg;
    assign dout.rem    = rem_reg;
    assign dout.stream = stream_reg;

endmodule

`default_nettype wire

### sv/pwg_phase.sv
// ============================================================================
// pwg_phase
// Time to phase: time * frequency, reduction to a 32-bit fraction of a
// turn through five division digits, then the phase offset.
// ============================================================================
`default_nettype none

module pwg_phase
    import pwg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [TIME_W-1:0]  time_usec,
    input  wire pwg_cfg_t           cfg,
    output logic                    out_valid,
    output logic [PHASE_W-1:0]      phase
);

    logic                v0_reg;
    logic [TIME_W-1:0]   time_reg;
    logic                v1_reg;
    logic [PART_W-1:0]   part_hi_reg;
    logic [PART_W-1:0]   part_lo_reg;
    logic                v2_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                v3_reg;
    logic [PHASE_W-1:0]  phase_reg;

    digit_bus_t chain [0:DIGIT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= chain[DIGIT_COUNT].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg    <= time_usec;
        part_hi_reg <= PART_W'(time_reg[TIME_W-1 -: TIME_HALF_W]) * PART_W'(cfg.frequency_hz);
        part_lo_reg <= PART_W'(time_reg[TIME_HALF_W-1:0]) * PART_W'(cfg.frequency_hz);
        prod_reg    <= {part_hi_reg, {TIME_HALF_W{1'b0}}} + PROD_W'(part_lo_reg);
        phase_reg   <= chain[DIGIT_COUNT].stream[PHASE_W-1:0] + cfg.phase_offset;
    end

    // Dividend is prod * 1024. Its top bits are already below the divisor
    // and seed the remainder; each digit shifts its quotient in at the bottom.
    assign chain[0].valid  = v2_reg;
    assign chain[0].rem    = REM_W'(prod_reg[PROD_W-1 -: DIV_TOP_W]);
    assign chain[0].stream = {prod_reg[PROD_W-DIV_TOP_W-1:0], {PHASE_PAD_W{1'b0}}};

    for (genvar g = 0; g < DIGIT_COUNT; g++)
    begin : g_digit
        pwg_div_digit u_digit (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    assign out_valid = v3_reg;
    assign phase     = phase_reg;

endmodule

`default_nettype wire

### sv/pwg_shape.sv
// ============================================================================
// pwg_shape
// Phase to Q1.14 shape value: sine/cosine from the quarter-wave ROM,
// square, triangle, sawtooth, or zero for offset only.
// ============================================================================
`default_nettype none

module pwg_shape
    import pwg_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [PHASE_W-1:0]  phase,
    input  wire pwg_cfg_t            cfg,
    output logic                     out_valid,
    output logic signed [SHAPE_W-1:0] shape
);

    logic                    v1_reg;
    logic [PHASE_W-1:0]      phase1_reg;
    logic [PHASE_W-1:0]      sine_phase_reg;
    logic                    v2_reg;
    logic [PHASE_W-1:0]      phase2_reg;
    logic                    neg2_reg;
    logic [SINE_W-1:0]       rom_q_reg;
    logic                    v3_reg;
    logic signed [SHAPE_W-1:0] shape_reg;

    logic [1:0]                 quad;
    logic [SINE_TABLE_LOG2-1:0] pos;
    logic [SINE_ADDR_W-1:0]     rom_addr;
    logic [SHAPE_W-1:0]         ph_hi;
    logic [SHAPE_W-1:0]         sine_mag;
    logic [SHAPE_W-1:0]         sine_val;
    logic [SHAPE_W-1:0]         tri_val;
    logic [SHAPE_W-1:0]         saw_val;
    logic [SHAPE_W-1:0]         sq_val;
    logic [SHAPE_W-1:0]         shape_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Quadrant symmetry: odd quadrants run the table backwards
    assign quad     = sine_phase_reg[PHASE_W-1 -: 2];
    assign pos      = sine_phase_reg[PHASE_W-3 -: SINE_TABLE_LOG2];
    assign rom_addr = quad[0] ? SINE_ADDR_W'(SINE_TBL_N) - {1'b0, pos} : {1'b0, pos};

    always_ff @(posedge clk)
    begin
        phase1_reg     <= phase;
        sine_phase_reg <= (cfg.wave_kind == WAVE_COSINE) ? phase + QUARTER_TURN : phase;
        phase2_reg     <= phase1_reg;
        neg2_reg       <= quad[1];
        rom_q_reg      <= SINE_ROM[rom_addr];
        shape_reg      <= $signed(shape_next);
    end

    // All values fit in 16 bits, so wrap-around arithmetic is exact
    assign ph_hi    = phase2_reg[PHASE_W-1 -: SHAPE_W];
    assign sine_mag = SHAPE_W'(rom_q_reg);
    assign sine_val = neg2_reg ? SHAPE_W'(0) - sine_mag : sine_mag;
    assign tri_val  = ph_hi[SHAPE_W-1] ? TRI_PEAK - ph_hi : ph_hi - SHAPE_ONE;
    assign saw_val  = {1'b0, ph_hi[SHAPE_W-1:1]} - SHAPE_ONE;
    assign sq_val   = ph_hi[SHAPE_W-1] ? SHAPE_MINUS_ONE : SHAPE_ONE;

    // Offset only yields zero, which the scaler turns into the bare offset
    always_comb
    begin
        case (cfg.wave_kind)
            WAVE_SINE, WAVE_COSINE: shape_next = sine_val;
            WAVE_SQUARE:            shape_next = sq_val;
            WAVE_TRIANGLE:          shape_next = tri_val;
            WAVE_SAWTOOTH:          shape_next = saw_val;
            WAVE_OFFSET:            shape_next = '0;
            default:                shape_next = '0;
        endcase
    end

    assign out_valid = v3_reg;
    assign shape     = shape_reg;

endmodule

`default_nettype wire

### sv/pwg_scale.sv
// ============================================================================
// pwg_scale
// Shape times amplitude, round to Q8.8, add offset, saturate to 16 bits.
// ============================================================================
`default_nettype none

module pwg_scale
    import pwg_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic signed [SHAPE_W-1:0]   shape,
    input  wire pwg_cfg_t                    cfg,
    output logic                             out_valid,
    output logic signed [SAMPLE_W-1:0]       sample
);

    localparam int MUL_W      = AMP_W + SHAPE_W;
    localparam int SUM_W      = 19;
    localparam int FRAC_SHIFT = 14;
    localparam logic signed [MUL_W-1:0]    ROUND_BIAS = 32'sd8192;
    localparam logic signed [SUM_W-1:0]    SAMPLE_MAX = 19'sd32767;
    localparam logic signed [SUM_W-1:0]    SAMPLE_MIN = -19'sd32768;

    logic signed [MUL_W-1:0] amp_ext;
    logic signed [MUL_W-1:0] shape_ext;
    logic                    v1_reg;
    logic signed [MUL_W-1:0] prod_reg;
    logic signed [MUL_W-1:0] rounded;
    logic signed [SUM_W-1:0] sum;
    logic signed [SAMPLE_W-1:0] sample_next;
    logic                    v2_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    assign amp_ext   = {{(MUL_W-AMP_W){cfg.amplitude[AMP_W-1]}}, cfg.amplitude};
    assign shape_ext = {{(MUL_W-SHAPE_W){shape[SHAPE_W-1]}}, shape};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Round half up, then arithmetic shift gives floor
    assign rounded = (prod_reg + ROUND_BIAS) >>> FRAC_SHIFT;
    assign sum     = rounded[SUM_W-1:0]
                   + {{(SUM_W-AMP_W){cfg.offset[AMP_W-1]}}, cfg.offset};

    always_comb
    begin
        if (sum > SAMPLE_MAX)
        begin
            sample_next = SAMPLE_MAX[SAMPLE_W-1:0];
        end
        else if (sum < SAMPLE_MIN)
        begin
            sample_next = SAMPLE_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            sample_next = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= amp_ext * shape_ext;
        sample_reg <= sample_next;
    end

    assign out_valid = v2_reg;
    assign sample    = sample_reg;

endmodule

`default_nettype wire

### sv/pwg_checker.sv
// ============================================================================
// pwg_checker
// Port-level checks for the waveform generator, bound to the top level.
// ============================================================================
`default_nettype none

module pwg_checker
    import pwg_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic                     done,
    input wire logic signed [SAMPLE_W-1:0] sample,
    input wire logic                     cfg_we,
    input wire logic [CFG_ADDR_W-1:0]    cfg_addr,
    input wire logic [CFG_DATA_W-1:0]    cfg_wdata
);

    logic              accepted;
    logic [KIND_W-1:0] kind_shadow_reg;
    logic [AMP_W-1:0]  offset_shadow_reg;

    assign accepted = start && !busy;

    // Track the registers that decide an offset-only sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_shadow_reg   <= WAVE_KIND_RESET;
            offset_shadow_reg <= OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_WAVE_KIND)
            begin
                kind_shadow_reg <= cfg_wdata[KIND_W-1:0];
            end
            if (cfg_addr == REG_OFFSET)
            begin
                offset_shadow_reg <= cfg_wdata[AMP_W-1:0];
            end
        end
    end

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |-> ##PIPE_LATENCY done)
        else $error("transfer without a result after the pipeline latency");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accepted, PIPE_LATENCY))
        else $error("result strobe without a matching input transfer");

    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("busy high after the first cycle out of reset");

    a_offset_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (kind_shadow_reg >= KIND_W'(WAVE_OFFSET)))
            |-> (sample == $signed(offset_shadow_reg)))
        else $error("offset-only sample differs from the offset register");

endmodule

bind periodic_waveform_generator pwg_checker u_pwg_checker (.*);

`default_nettype wire
